### sv/wph_pkg.sv
// Shared types, constants and helper functions of the WAV header parser.
`timescale 1ns / 1ps

package wph_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HDR   = 3'd0,
        PH_CHUNK = 3'd1,
        PH_FMT   = 3'd2,
        PH_SKIP  = 3'd3,
        PH_DATA  = 3'd4,
        PH_IDLE  = 3'd5
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_FORMAT  = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_ID3       = 3'd0;
    localparam logic [2:0] ERR_NOT_RIFF  = 3'd1;
    localparam logic [2:0] ERR_NOT_WAVE  = 3'd2;
    localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
    localparam logic [2:0] ERR_NOT_16BIT = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    // Four-character codes, first character in the top byte
    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;
    localparam logic [31:0] TAG_ID32 = 32'h49443302;
    localparam logic [31:0] TAG_ID33 = 32'h49443303;

    // Byte positions inside headers
    localparam logic [4:0] POS_TAG_END  = 5'd3;
    localparam logic [4:0] POS_FMT_TAG  = 5'd1;
    localparam logic [4:0] POS_FMT_CH   = 5'd3;
    localparam logic [4:0] POS_FMT_RATE = 5'd7;
    localparam logic [4:0] POS_CHUNK_END = 5'd7;
    localparam logic [4:0] POS_HDR_END  = 5'd11;
    localparam logic [4:0] POS_FMT_END  = 5'd15;

    localparam logic [31:0] FMT_BODY_LEN  = 32'd16;
    localparam logic [15:0] FMT_PCM       = 16'd1;
    localparam logic [15:0] FMT_BITS16    = 16'd16;

    localparam int TDATA_OUT_W = 64;

    typedef struct packed {
        logic       start_req;
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        last_payload;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [2:0]  error_code;
    } result_t;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [15:0] swap16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    function automatic result_t make_error(input logic [2:0] code);
        result_t r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

endpackage

### sv/wav_pcm16_header_parser_top.sv
// A byte with a result passes the input register, then the result register.
// Throughput: one byte per cycle unless m_tready stalls; the input and result
// registers each hold one transfer, so one more byte is taken while a result
// waits for m_tready. Each byte takes one pass through the parser state logic.
// Reset: rst_n clears both stages and returns the parser to the RIFF header.
`timescale 1ns / 1ps

module wav_pcm16_header_parser_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // [0] start_req
    input  logic                            s_tlast,   // stream_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] payload_byte, [23:8] channel_count, [55:24] sample_rate,
    // [58:56] error_code, [63:59] zero
    output logic [wph_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic [1:0]                      m_tuser,   // [1:0] kind
    output logic                            m_tlast    // last_payload
);

    logic              item_valid;
    wph_pkg::in_item_t item;
    logic              advance;
    logic              res_valid;
    wph_pkg::result_t  res;

    // advance the held byte whenever the result register can take a result
    assign advance = item_valid && (!m_tvalid || m_tready);

    wph_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    wph_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    wph_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && res_valid),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_tlast_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == wph_pkg::KIND_PAYLOAD)
        else $error("tlast set on a non-payload result");

    a_error_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == wph_pkg::KIND_ERROR) |-> m_tdata[58:56] <= wph_pkg::ERR_TRUNCATED)
        else $error("error code out of range");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid |-> s_tready)
        else $error("input stalled with an empty input register");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid |=> m_tvalid)
        else $error("result lost on load");

endmodule

### sv/wph_in_stage.sv
// Input register of the WAV header parser: holds one accepted byte transfer.
`timescale 1ns / 1ps

module wph_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tuser,   // [0] start_req
    input  logic              s_tlast,   // stream_end
    input  logic              advance,
    output logic              item_valid,
    output wph_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    wph_pkg::in_item_t item_reg;
    logic              load;

    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.start_req  <= s_tuser;
            item_reg.data_byte  <= s_tdata;
            item_reg.stream_end <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### sv/wph_parser.sv
// Parser state and per-byte step logic of the WAV header parser.
`timescale 1ns / 1ps

module wph_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  wph_pkg::in_item_t item,
    output logic              res_valid,
    output wph_pkg::result_t  res
);

    wph_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic [4:0]  pos_reg, pos_next, cur_pos;
    logic [31:0] shift_reg, shift_next, cur_shift;
    logic [31:0] tag_reg, tag_next, cur_tag;
    logic [31:0] rem_reg, rem_next, cur_rem;
    logic [15:0] ch_reg, ch_next, cur_ch;
    logic [31:0] rate_reg, rate_next, cur_rate;
    logic [31:0] sw;
    logic [31:0] size;
    logic        end_flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= wph_pkg::PH_HDR;
            pos_reg   <= '0;
            shift_reg <= '0;
            tag_reg   <= '0;
            rem_reg   <= '0;
            ch_reg    <= '0;
            rate_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            tag_reg   <= tag_next;
            rem_reg   <= rem_next;
            ch_reg    <= ch_next;
            rate_reg  <= rate_next;
        end
    end

    always_comb
    begin
        // start_req restarts from the reset state on this same byte
        if (item.start_req)
        begin
            cur_phase = wph_pkg::PH_HDR;
            cur_pos   = '0;
            cur_shift = '0;
            cur_tag   = '0;
            cur_rem   = '0;
            cur_ch    = '0;
            cur_rate  = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_pos   = pos_reg;
            cur_shift = shift_reg;
            cur_tag   = tag_reg;
            cur_rem   = rem_reg;
            cur_ch    = ch_reg;
            cur_rate  = rate_reg;
        end

        end_flag = item.stream_end;
        sw       = {cur_shift[23:0], item.data_byte};
        size     = wph_pkg::swap32(sw);

        phase_next = phase_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        tag_next   = tag_reg;
        rem_next   = rem_reg;
        ch_next    = ch_reg;
        rate_next  = rate_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (advance)
        begin
            phase_next = cur_phase;
            pos_next   = cur_pos;
            shift_next = cur_shift;
            tag_next   = cur_tag;
            rem_next   = cur_rem;
            ch_next    = cur_ch;
            rate_next  = cur_rate;

            case (cur_phase)
                wph_pkg::PH_DATA:
                begin
                    res_valid = 1'b1;
                    if (end_flag && (cur_rem != 32'd1))
                    begin
                        phase_next = wph_pkg::PH_IDLE;
                        res        = wph_pkg::make_error(wph_pkg::ERR_TRUNCATED);
                    end
                    else
                    begin
                        rem_next         = cur_rem - 32'd1;
                        res.kind         = wph_pkg::KIND_PAYLOAD;
                        res.payload_byte = item.data_byte;
                        res.last_payload = (cur_rem == 32'd1);
                        if (cur_rem == 32'd1)
                        begin
                            phase_next = wph_pkg::PH_IDLE;
                        end
                    end
                end

                wph_pkg::PH_SKIP:
                begin
                    if (end_flag)
                    begin
                        phase_next = wph_pkg::PH_IDLE;
                        res_valid  = 1'b1;
                        res        = wph_pkg::make_error(wph_pkg::ERR_TRUNCATED);
                    end
                    else
                    begin
                        rem_next = cur_rem - 32'd1;
                        if (cur_rem == 32'd1)
                        begin
                            phase_next = wph_pkg::PH_CHUNK;
                            pos_next   = '0;
                        end
                    end
                end

                wph_pkg::PH_HDR:
                begin
                    shift_next = sw;
                    pos_next   = cur_pos + 5'd1;
                    if (cur_pos == wph_pkg::POS_TAG_END)
                    begin
                        tag_next = sw;
                    end
                    if (cur_pos < wph_pkg::POS_HDR_END)
                    begin
                        if (end_flag)
                        begin
                            phase_next = wph_pkg::PH_IDLE;
                            res_valid  = 1'b1;
                            res        = wph_pkg::make_error(wph_pkg::ERR_TRUNCATED);
                        end
                    end
                    else if ((cur_tag == wph_pkg::TAG_ID32) || (cur_tag == wph_pkg::TAG_ID33))
                    begin
                        phase_next = wph_pkg::PH_IDLE;
                        res_valid  = 1'b1;
                        res        = wph_pkg::make_error(wph_pkg::ERR_ID3);
                    end
                    else if (cur_tag != wph_pkg::TAG_RIFF)
                    begin
                        phase_next = wph_pkg::PH_IDLE;
                        res_valid  = 1'b1;
                        res        = wph_pkg::make_error(wph_pkg::ERR_NOT_RIFF);
                    end
                    else if (sw != wph_pkg::TAG_WAVE)
                    begin
                        phase_next = wph_pkg::PH_IDLE;
                        res_valid  = 1'b1;
                        res        = wph_pkg::make_error(wph_pkg::ERR_NOT_WAVE);
                    end
                    else if (end_flag)
                    begin
                        phase_next = wph_pkg::PH_IDLE;
                        res_valid  = 1'b1;
                        res        = wph_pkg::make_error(wph_pkg::ERR_TRUNCATED);
                    end
                    else
                    begin
                        phase_next = wph_pkg::PH_CHUNK;
                        pos_next   = '0;
                    end
                end

                wph_pkg::PH_CHUNK:
                begin
                    shift_next = sw;
                    pos_next   = cur_pos + 5'd1;
                    if (cur_pos == wph_pkg::POS_TAG_END)
                    begin
                        tag_next = sw;
                    end
                    if (cur_pos < wph_pkg::POS_CHUNK_END)
                    begin
                        if (end_flag)
                        begin
                            phase_next = wph_pkg::PH_IDLE;
                            res_valid  = 1'b1;
                            res        = wph_pkg::make_error(wph_pkg::ERR_TRUNCATED);
                        end
                    end
                    else
                    begin
                        pos_next = '0;
                        if ((cur_tag == wph_pkg::TAG_DATA) && (size == 32'd0))
                        begin
                            // empty data chunk ends the file even on stream end
                            phase_next = wph_pkg::PH_IDLE;
                            res_valid  = 1'b1;
                            res.kind   = wph_pkg::KIND_EMPTY;
                        end
                        else if (end_flag)
                        begin
                            phase_next = wph_pkg::PH_IDLE;
                            res_valid  = 1'b1;
                            res        = wph_pkg::make_error(wph_pkg::ERR_TRUNCATED);
                        end
                        else if (cur_tag == wph_pkg::TAG_DATA)
                        begin
                            phase_next = wph_pkg::PH_DATA;
                            rem_next   = size;
                        end
                        else if (cur_tag == wph_pkg::TAG_FMT)
                        begin
                            phase_next = wph_pkg::PH_FMT;
                            rem_next   = (size >= wph_pkg::FMT_BODY_LEN) ?
                                         (size - wph_pkg::FMT_BODY_LEN) : 32'd0;
                        end
                        else if (size == 32'd0)
                        begin
                            phase_next = wph_pkg::PH_CHUNK;
                        end
                        else
                        begin
                            phase_next = wph_pkg::PH_SKIP;
                            rem_next   = size;
                        end
                    end
                end

                wph_pkg::PH_FMT:
                begin
                    shift_next = sw;
                    pos_next   = cur_pos + 5'd1;
                    if (cur_pos == wph_pkg::POS_FMT_TAG)
                    begin
                        tag_next = {16'h0000, wph_pkg::swap16(sw[15:0])};
                    end
                    else if (cur_pos == wph_pkg::POS_FMT_CH)
                    begin
                        ch_next = wph_pkg::swap16(sw[15:0]);
                    end
                    else if (cur_pos == wph_pkg::POS_FMT_RATE)
                    begin
                        rate_next = size;
                    end

                    if (cur_pos < wph_pkg::POS_FMT_END)
                    begin
                        if (end_flag)
                        begin
                            phase_next = wph_pkg::PH_IDLE;
                            res_valid  = 1'b1;
                            res        = wph_pkg::make_error(wph_pkg::ERR_TRUNCATED);
                        end
                    end
                    else if (cur_tag != {16'h0000, wph_pkg::FMT_PCM})
                    begin
                        phase_next = wph_pkg::PH_IDLE;
                        res_valid  = 1'b1;
                        res        = wph_pkg::make_error(wph_pkg::ERR_NOT_PCM);
                    end
                    else if (wph_pkg::swap16(sw[15:0]) != wph_pkg::FMT_BITS16)
                    begin
                        phase_next = wph_pkg::PH_IDLE;
                        res_valid  = 1'b1;
                        res        = wph_pkg::make_error(wph_pkg::ERR_NOT_16BIT);
                    end
                    else if (end_flag)
                    begin
                        phase_next = wph_pkg::PH_IDLE;
                        res_valid  = 1'b1;
                        res        = wph_pkg::make_error(wph_pkg::ERR_TRUNCATED);
                    end
                    else
                    begin
                        pos_next          = '0;
                        phase_next        = (cur_rem == 32'd0) ? wph_pkg::PH_CHUNK
                                                               : wph_pkg::PH_SKIP;
                        res_valid         = 1'b1;
                        res.kind          = wph_pkg::KIND_FORMAT;
                        res.channel_count = cur_ch;
                        res.sample_rate   = cur_rate;
                    end
                end

                default:
                begin
                    // idle: drop the byte
                    phase_next = cur_phase;
                end
            endcase
        end
    end

endmodule

### sv/wph_out_stage.sv
// Output register of the WAV header parser: holds one result until transfer.
`timescale 1ns / 1ps

module wph_out_stage (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  wph_pkg::result_t                     res,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] payload_byte, [23:8] channel_count, [55:24] sample_rate,
    // [58:56] error_code, [63:59] zero
    output logic [wph_pkg::TDATA_OUT_W-1:0]      m_tdata,
    output logic [1:0]                           m_tuser,   // [1:0] kind
    output logic                                 m_tlast    // last_payload
);

    logic             valid_reg;
    logic             valid_next;
    wph_pkg::result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last_payload;
    assign m_tdata  = {5'b00000, res_reg.error_code, res_reg.sample_rate,
                       res_reg.channel_count, res_reg.payload_byte};

endmodule

### bench/wph_checker.sv
// Result checker of the WAV header parser: predicts the report of each byte and compares.
`timescale 1ns / 1ps

module wph_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // [0] start_req
    input  logic                            s_tlast,   // stream_end
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] payload_byte, [23:8] channel_count, [55:24] sample_rate,
    // [58:56] error_code, [63:59] zero
    input  logic [wph_pkg::TDATA_OUT_W-1:0] m_tdata,
    input  logic [1:0]                      m_tuser,   // [1:0] kind
    input  logic                            m_tlast,   // last_payload
    output int                              errors,
    output int                              reports_due
);

    // Parser state as the block should hold it
    wph_pkg::phase_t  stage;
    logic [4:0]       byte_idx;
    logic [31:0]      window;
    logic [31:0]      tag_word;
    logic [31:0]      left;
    logic [15:0]      chans;
    logic [31:0]      rate_hz;

    wph_pkg::result_t report_q[$];
    wph_pkg::result_t want;
    wph_pkg::result_t rep;
    logic             emit;
    logic             bad;
    logic [2:0]       code;
    logic [4:0]       at;
    logic [31:0]      size;

    task automatic report_mismatch(input string msg);
        $display("[%0t] checker: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned exp_val);
        if (got != exp_val)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, exp_val));
    endtask

    task automatic restart_parser();
        stage    = wph_pkg::PH_HDR;
        byte_idx = '0;
        window   = '0;
        tag_word = '0;
        left     = '0;
        chans    = '0;
        rate_hz  = '0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            report_q.delete();
            restart_parser();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (report_q.size() == 0)
                    report_mismatch($sformatf("result of kind %0d with nothing expected",
                                              m_tuser));
                else
                begin
                    want = report_q.pop_front();
                    check_field("kind", m_tuser, want.kind);
                    check_field("payload_byte", m_tdata[7:0], want.payload_byte);
                    check_field("last_payload", m_tlast, want.last_payload);
                    check_field("channel_count", m_tdata[23:8], want.channel_count);
                    check_field("sample_rate", m_tdata[55:24], want.sample_rate);
                    check_field("error_code", m_tdata[58:56], want.error_code);
                end
            end

            if (s_tvalid && s_tready)
            begin
                rep  = '0;
                emit = 1'b0;
                bad  = 1'b0;
                code = wph_pkg::ERR_TRUNCATED;
                if (s_tuser)
                    restart_parser();
                case (stage)
                    wph_pkg::PH_DATA:
                    begin
                        if (s_tlast && left != 32'd1)
                            bad = 1'b1;
                        else
                        begin
                            emit             = 1'b1;
                            rep.kind         = wph_pkg::KIND_PAYLOAD;
                            rep.payload_byte = s_tdata;
                            rep.last_payload = (left == 32'd1);
                            if (left == 32'd1)
                                stage = wph_pkg::PH_IDLE;
                            left = left - 32'd1;
                        end
                    end
                    wph_pkg::PH_SKIP:
                    begin
                        if (s_tlast)
                            bad = 1'b1;
                        else
                        begin
                            left = left - 32'd1;
                            if (left == 32'd0)
                            begin
                                stage    = wph_pkg::PH_CHUNK;
                                byte_idx = '0;
                            end
                        end
                    end
                    wph_pkg::PH_HDR, wph_pkg::PH_CHUNK, wph_pkg::PH_FMT:
                    begin
                        window   = {window[23:0], s_tdata};
                        at       = byte_idx;
                        byte_idx = byte_idx + 5'd1;
                        if (stage == wph_pkg::PH_HDR)
                        begin
                            if (at == wph_pkg::POS_TAG_END)
                                tag_word = window;
                            if (at < wph_pkg::POS_HDR_END)
                                bad = s_tlast;
                            else if (tag_word == wph_pkg::TAG_ID32 ||
                                     tag_word == wph_pkg::TAG_ID33)
                            begin
                                bad  = 1'b1;
                                code = wph_pkg::ERR_ID3;
                            end
                            else if (tag_word != wph_pkg::TAG_RIFF)
                            begin
                                bad  = 1'b1;
                                code = wph_pkg::ERR_NOT_RIFF;
                            end
                            else if (window != wph_pkg::TAG_WAVE)
                            begin
                                bad  = 1'b1;
                                code = wph_pkg::ERR_NOT_WAVE;
                            end
                            else if (s_tlast)
                                bad = 1'b1;
                            else
                            begin
                                stage    = wph_pkg::PH_CHUNK;
                                byte_idx = '0;
                            end
                        end
                        else if (stage == wph_pkg::PH_CHUNK)
                        begin
                            if (at == wph_pkg::POS_TAG_END)
                                tag_word = window;
                            if (at < wph_pkg::POS_CHUNK_END)
                                bad = s_tlast;
                            else
                            begin
                                // size field is little-endian
                                size     = {window[7:0], window[15:8],
                                            window[23:16], window[31:24]};
                                byte_idx = '0;
                                if (tag_word == wph_pkg::TAG_DATA && size == 32'd0)
                                begin
                                    stage    = wph_pkg::PH_IDLE;
                                    emit     = 1'b1;
                                    rep.kind = wph_pkg::KIND_EMPTY;
                                end
                                else if (s_tlast)
                                    bad = 1'b1;
                                else if (tag_word == wph_pkg::TAG_DATA)
                                begin
                                    stage = wph_pkg::PH_DATA;
                                    left  = size;
                                end
                                else if (tag_word == wph_pkg::TAG_FMT)
                                begin
                                    stage = wph_pkg::PH_FMT;
                                    left  = (size >= wph_pkg::FMT_BODY_LEN) ?
                                            size - wph_pkg::FMT_BODY_LEN : 32'd0;
                                end
                                else if (size != 32'd0)
                                begin
                                    stage = wph_pkg::PH_SKIP;
                                    left  = size;
                                end
                            end
                        end
                        else
                        begin
                            if (at == wph_pkg::POS_FMT_TAG)
                                tag_word = {16'h0, window[7:0], window[15:8]};
                            else if (at == wph_pkg::POS_FMT_CH)
                                chans = {window[7:0], window[15:8]};
                            else if (at == wph_pkg::POS_FMT_RATE)
                                rate_hz = {window[7:0], window[15:8],
                                           window[23:16], window[31:24]};
                            if (at < wph_pkg::POS_FMT_END)
                                bad = s_tlast;
                            else if (tag_word != {16'h0, wph_pkg::FMT_PCM})
                            begin
                                bad  = 1'b1;
                                code = wph_pkg::ERR_NOT_PCM;
                            end
                            else if ({window[7:0], window[15:8]} != wph_pkg::FMT_BITS16)
                            begin
                                bad  = 1'b1;
                                code = wph_pkg::ERR_NOT_16BIT;
                            end
                            else if (s_tlast)
                                bad = 1'b1;
                            else
                            begin
                                byte_idx          = '0;
                                stage             = (left == 32'd0) ? wph_pkg::PH_CHUNK
                                                                    : wph_pkg::PH_SKIP;
                                emit              = 1'b1;
                                rep.kind          = wph_pkg::KIND_FORMAT;
                                rep.channel_count = chans;
                                rep.sample_rate   = rate_hz;
                            end
                        end
                    end
                    default:
                    begin
                        // idle: drop the byte
                    end
                endcase
                if (bad)
                begin
                    stage          = wph_pkg::PH_IDLE;
                    rep            = '0;
                    rep.kind       = wph_pkg::KIND_ERROR;
                    rep.error_code = code;
                    emit           = 1'b1;
                end
                if (emit)
                    report_q.push_back(rep);
            end
        end
        reports_due = report_q.size();
    end

endmodule

### bench/tb.sv
// Testbench top of the WAV header parser: clock, reset, byte streams and the verdict.
`timescale 1ns / 1ps

module tb;

    localparam int ITEM_TARGET  = 520;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata  = '0;
    logic                            s_tuser  = 1'b0;
    logic                            s_tlast  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [wph_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic [1:0]                      m_tuser;
    logic                            m_tlast;

    int         errors;
    int         reports_due;
    logic       calm          = 1'b0;
    int         bytes_sent    = 0;
    int         silent_cycles = 0;
    int         hold_left     = 0;
    logic [7:0] file_bytes[$];

    always #5 clk = ~clk;

    wav_pcm16_header_parser_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    wph_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .errors      (errors),
        .reports_due (reports_due)
    );

    // Result side: stall now and then
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 10)
        begin
            hold_left <= int'($urandom_range(0, 3));
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            silent_cycles <= 0;
        else
        begin
            silent_cycles <= silent_cycles + 1;
            if (silent_cycles == STALL_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    function automatic void put_tag(input logic [31:0] t);
        file_bytes.push_back(t[31:24]);
        file_bytes.push_back(t[23:16]);
        file_bytes.push_back(t[15:8]);
        file_bytes.push_back(t[7:0]);
    endfunction

    function automatic void put_le16(input logic [15:0] v);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
    endfunction

    function automatic void put_le32(input logic [31:0] v);
        put_le16(v[15:0]);
        put_le16(v[31:16]);
    endfunction

    function automatic void put_header(input logic [31:0] lead_tag, input logic [31:0] form);
        put_tag(lead_tag);
        put_le32($urandom());
        put_tag(form);
    endfunction

    // fmt chunk: 16-byte body always, plus a tail when size is above 16
    function automatic void put_fmt(input logic [15:0] fmt_code, input logic [15:0] ch,
                                    input logic [31:0] rate, input logic [15:0] bits,
                                    input logic [31:0] size);
        put_tag(wph_pkg::TAG_FMT);
        put_le32(size);
        put_le16(fmt_code);
        put_le16(ch);
        put_le32(rate);
        put_le32($urandom());
        put_le16(16'($urandom()));
        put_le16(bits);
        if (size > wph_pkg::FMT_BODY_LEN)
            repeat (size - wph_pkg::FMT_BODY_LEN) file_bytes.push_back(8'($urandom()));
    endfunction

    function automatic void put_skip(input logic [31:0] size, input int count);
        put_tag($urandom());
        put_le32(size);
        repeat (count) file_bytes.push_back(8'($urandom()));
    endfunction

    function automatic void put_data(input logic [31:0] size, input int count);
        put_tag(wph_pkg::TAG_DATA);
        put_le32(size);
        repeat (count) file_bytes.push_back(8'($urandom()));
    endfunction

    // Send the first keep bytes (all if keep is 0); lead flags the first one as a
    // new file, fin marks the last one sent as the end of the stream.
    task automatic send_file(input logic lead, input int keep, input logic fin);
        int n;
        n = (keep <= 0 || keep > file_bytes.size()) ? file_bytes.size() : keep;
        for (int i = 0; i < n; i++)
        begin
            if (!calm && $urandom_range(0, 99) < 10)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= lead && i == 0;
            s_tdata  <= file_bytes[i];
            s_tlast  <= fin && i == n - 1;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            bytes_sent++;
            @(negedge clk);
        end
        file_bytes.delete();
    endtask

    // Hold the sender until every expected report has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (reports_due != 0) @(negedge clk);
    endtask

    initial
    begin
        int          keep;
        logic        fin;
        logic        lead;
        int          pick;
        int          file_no;
        logic [31:0] lead_tag;
        logic [31:0] form;
        logic [31:0] size;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Parser starts on the RIFF header without a start flag; widest fmt fields
        put_header(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(wph_pkg::FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, wph_pkg::FMT_BITS16,
                wph_pkg::FMT_BODY_LEN);
        put_tag(wph_pkg::TAG_DATA);
        put_le32(32'd2);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        send_file(1'b0, 0, 1'b1);
        // ID3 signatures
        put_header(wph_pkg::TAG_ID32, wph_pkg::TAG_WAVE);
        send_file(1'b1, 0, 1'b0);
        put_header(wph_pkg::TAG_ID33, wph_pkg::TAG_WAVE);
        send_file(1'b1, 0, 1'b0);
        // bytes after an error without a start flag are dropped
        put_header(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        send_file(1'b0, 0, 1'b0);
        put_header(wph_pkg::TAG_RIFF ^ 32'h1, wph_pkg::TAG_WAVE);
        send_file(1'b1, 0, 1'b0);
        // format error wins over stream end on the completing byte
        put_header(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE ^ 32'h100);
        send_file(1'b1, 0, 1'b1);
        put_header(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        send_file(1'b1, 6, 1'b1);
        put_header(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        send_file(1'b1, 0, 1'b1);
        put_header(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16'd3, 16'd2, 32'd44100, wph_pkg::FMT_BITS16, wph_pkg::FMT_BODY_LEN);
        send_file(1'b1, 36, 1'b1);
        put_header(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(wph_pkg::FMT_PCM, 16'd2, 32'd44100, 16'd8, wph_pkg::FMT_BODY_LEN);
        send_file(1'b1, 0, 1'b0);
        // stream end replaces the format report
        put_header(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(wph_pkg::FMT_PCM, 16'd0, 32'd0, wph_pkg::FMT_BITS16, wph_pkg::FMT_BODY_LEN);
        send_file(1'b1, 36, 1'b1);
        // short fmt size, then an empty data chunk that also ends the stream
        put_header(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(wph_pkg::FMT_PCM, 16'd1, 32'd8000, wph_pkg::FMT_BITS16, 32'd8);
        put_data(32'd0, 0);
        send_file(1'b1, 0, 1'b1);

        // no idling on either side through the next files
        calm = 1'b1;
        // unknown chunks, fmt tail, junk after the data
        put_header(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_skip(32'd0, 0);
        put_skip(32'd3, 3);
        put_fmt(wph_pkg::FMT_PCM, 16'd2, 32'd48000, wph_pkg::FMT_BITS16, 32'd18);
        put_data(32'd3, 5);
        send_file(1'b1, 0, 1'b1);
        // stream ends inside data, on the data size, inside a skipped chunk
        put_header(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(wph_pkg::FMT_PCM, 16'd1, 32'd22050, wph_pkg::FMT_BITS16,
                wph_pkg::FMT_BODY_LEN);
        put_data(32'd4, 4);
        send_file(1'b1, 46, 1'b1);
        put_header(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(wph_pkg::FMT_PCM, 16'd1, 32'd22050, wph_pkg::FMT_BITS16,
                wph_pkg::FMT_BODY_LEN);
        put_data(32'd4, 4);
        send_file(1'b1, 44, 1'b1);
        put_header(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_skip(32'd5, 5);
        send_file(1'b1, 22, 1'b1);
        // cut mid-fmt; the next file restarts the parser
        put_header(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(wph_pkg::FMT_PCM, 16'd2, 32'd96000, wph_pkg::FMT_BITS16,
                wph_pkg::FMT_BODY_LEN);
        send_file(1'b1, 20, 1'b0);
        calm = 1'b0;

        file_no = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            if (file_no == 0 || $urandom_range(0, 9) == 0)
                wait_drained();
            file_no++;

            pick = int'($urandom_range(0, 99));
            if (pick < 5)
            begin
                // noise
                repeat ($urandom_range(1, 16)) file_bytes.push_back(8'($urandom()));
            end
            else
            begin
                if (pick < 8)
                    lead_tag = $urandom_range(0, 1) ? wph_pkg::TAG_ID32 : wph_pkg::TAG_ID33;
                else if (pick < 11)
                    lead_tag = $urandom();
                else
                    lead_tag = wph_pkg::TAG_RIFF;
                form = (pick >= 11 && pick < 14) ? $urandom() : wph_pkg::TAG_WAVE;
                put_header(lead_tag, form);
                repeat ($urandom_range(0, 2))
                begin
                    size = $urandom_range(0, 6);
                    put_skip(size, int'(size));
                end
                if ($urandom_range(0, 99) < 3)
                    put_skip($urandom(), int'($urandom_range(0, 4)));
                if ($urandom_range(0, 9) != 0)
                begin
                    pick = int'($urandom_range(0, 99));
                    if (pick < 70)
                        size = wph_pkg::FMT_BODY_LEN;
                    else if (pick < 85)
                        size = $urandom_range(17, 20);
                    else
                        size = $urandom_range(0, 15);
                    put_fmt(($urandom_range(0, 99) < 8) ? 16'($urandom()) : wph_pkg::FMT_PCM,
                            16'($urandom()), $urandom(),
                            ($urandom_range(0, 99) < 8) ? 16'($urandom())
                                                        : wph_pkg::FMT_BITS16, size);
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    size = $urandom_range(0, 6);
                    put_skip(size, int'(size));
                end
                pick = int'($urandom_range(0, 99));
                if (pick < 10)
                    size = 32'd0;
                else if (pick < 14)
                    size = $urandom();
                else
                    size = $urandom_range(1, 12);
                put_data(size, (size > 12) ? int'($urandom_range(0, 6)) : int'(size));
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom()));
            end

            lead = ($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 99) < 15)
            begin
                keep = int'($urandom_range(1, file_bytes.size()));
                fin  = 1'b1;
            end
            else
            begin
                keep = 0;
                fin  = 1'($urandom_range(0, 1));
            end
            send_file(lead, keep, fin);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
